>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LIA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/lia_pkg.sv
// Types and constants of the lookup-table accumulate block.
package lia_pkg;

  localparam int GROUPS            = 16;
  localparam int ACC_DEPTH         = 256;
  localparam int ENTRIES_PER_GROUP = 16;
  localparam int LUT_DEPTH         = GROUPS * ENTRIES_PER_GROUP;
  localparam int LUT_AW            = $clog2(LUT_DEPTH);
  localparam int ACC_AW            = $clog2(ACC_DEPTH);
  localparam int ACC_W             = 32;
  localparam int ENTRY_W           = 8;

  typedef enum logic [1:0] {
    OP_LUT_WRITE  = 2'd0,
    OP_ACCUMULATE = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUT_HI,
    ST_ACC_LO,
    ST_ACC_HI,
    ST_READ
  } state_t;

endpackage

>>> src/lia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lut_int8_int32_accumulate.sv
// Top level: 4-bit index table lookup with 32-bit accumulators in RAM.
// Entry write and clear complete when accepted; a read passes through the
// accumulator RAM read register, then waits for the output register to be free.
// An index byte goes through two table reads and two read-modify-writes
// through the single read port of the accumulator RAM.
// Reset clears control and per-entry valid bits, so accumulators read zero;
// lookup entries stay undefined until written.
module lut_int8_int32_accumulate
  import lia_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic [3:0]               lut_group,
  input  logic [3:0]               lut_slot,
  input  logic signed [7:0]        lut_value,
  input  logic [7:0]               index_byte,
  input  logic [2:0]               row_block,
  input  logic [3:0]               byte_position,
  input  logic [7:0]               read_address,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       read_value
);

  state_t state, state_next;

  // held item context
  logic [3:0]          grp;
  logic [3:0]          idx_hi;
  logic [ACC_AW-1:0]   lo_addr;
  logic [ACC_AW-1:0]   hi_addr;
  logic                lo_ok;
  logic                hi_ok;
  logic [ACC_AW-1:0]   rd_addr;
  logic                rd_ok;
  logic [ENTRY_W-1:0]  lo_entry;
  logic [ENTRY_W-1:0]  hi_entry;
  logic [ACC_DEPTH-1:0] acc_valid;

  // RAM ports
  logic                lut_we;
  logic [LUT_AW-1:0]   lut_waddr;
  logic                lut_re;
  logic [LUT_AW-1:0]   lut_raddr;
  logic [ENTRY_W-1:0]  lut_rdata;
  logic                acc_we;
  logic [ACC_AW-1:0]   acc_waddr;
  logic [ACC_W-1:0]    acc_wdata;
  logic                acc_re;
  logic [ACC_AW-1:0]   acc_raddr;
  logic [ACC_W-1:0]    acc_rdata;

  op_t                 op;
  logic                accept;
  logic                grp_ok;
  logic [7:0]          lo_full;
  logic [7:0]          hi_full;
  logic                out_free;
  logic                clear_all;
  logic                load_out;
  logic [ACC_W-1:0]    acc_old;
  logic [ENTRY_W-1:0]  add_entry;

  assign op       = op_t'(operation);
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign grp_ok   = 32'(lut_group) < GROUPS;
  assign lo_full  = {row_block, 1'b0, byte_position};
  assign hi_full  = {row_block, 1'b1, byte_position};
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    lut_we     = 1'b0;
    lut_waddr  = LUT_AW'({lut_group, lut_slot});
    lut_re     = 1'b0;
    lut_raddr  = LUT_AW'({lut_group, index_byte[3:0]});
    acc_we     = 1'b0;
    acc_waddr  = lo_addr;
    acc_re     = 1'b0;
    acc_raddr  = ACC_AW'(read_address);
    clear_all  = 1'b0;
    load_out   = 1'b0;
    acc_old    = '0;
    add_entry  = lo_entry;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LUT_WRITE: begin
              lut_we = grp_ok;
            end
            OP_ACCUMULATE: begin
              if (grp_ok) begin
                lut_re     = 1'b1;
                state_next = ST_LUT_HI;
              end
            end
            OP_CLEAR: begin
              clear_all = 1'b1;
            end
            OP_READ: begin
              acc_re     = 1'b1;
              state_next = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_LUT_HI: begin
        lut_re     = 1'b1;
        lut_raddr  = LUT_AW'({grp, idx_hi});
        acc_re     = 1'b1;
        acc_raddr  = lo_addr;
        state_next = ST_ACC_LO;
      end
      ST_ACC_LO: begin
        acc_old    = acc_valid[lo_addr] ? acc_rdata : '0;
        add_entry  = lo_entry;
        acc_we     = lo_ok;
        acc_waddr  = lo_addr;
        acc_re     = 1'b1;
        acc_raddr  = hi_addr;
        state_next = ST_ACC_HI;
      end
      ST_ACC_HI: begin
        acc_old    = acc_valid[hi_addr] ? acc_rdata : '0;
        add_entry  = hi_entry;
        acc_we     = hi_ok;
        acc_waddr  = hi_addr;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        // wait here until the output register can take the word
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    acc_wdata = acc_old + {{(ACC_W-ENTRY_W){add_entry[ENTRY_W-1]}}, add_entry};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp     <= lut_group;
      idx_hi  <= index_byte[7:4];
      lo_addr <= ACC_AW'(lo_full);
      hi_addr <= ACC_AW'(hi_full);
      lo_ok   <= 32'(lo_full) < ACC_DEPTH;
      hi_ok   <= 32'(hi_full) < ACC_DEPTH;
      rd_addr <= ACC_AW'(read_address);
      rd_ok   <= 32'(read_address) < ACC_DEPTH;
    end
    if (state == ST_LUT_HI) begin
      lo_entry <= lut_rdata;
    end
    if (state == ST_ACC_LO) begin
      hi_entry <= lut_rdata;
    end
    if (load_out) begin
      read_value <= (rd_ok && acc_valid[rd_addr]) ? acc_rdata : '0;
    end
  end

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      acc_valid <= '0;
    end else if (acc_we) begin
      acc_valid[acc_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  lia_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LUT_DEPTH)
  ) u_lut_ram (
    .clk   (clk),
    .we    (lut_we),
    .waddr (lut_waddr),
    .wdata (lut_value),
    .re    (lut_re),
    .raddr (lut_raddr),
    .rdata (lut_rdata)
  );

  lia_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

endmodule

>>> src/lia_checker.sv
// Port-level checker for the lookup-table accumulate block, with its bind.
`include "assert_macros.svh"

module lia_checker
  import lia_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] read_value
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `LIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `LIA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(read_value))
  `LIA_ASSERT_NEXT(a_read_busy, in_acc && operation == OP_READ, !in_ready)
  `LIA_ASSERT_NEXT(a_clear_one_cycle,
                   in_acc && (operation == OP_CLEAR || operation == OP_LUT_WRITE),
                   in_ready)

endmodule

bind lut_int8_int32_accumulate lia_checker u_lia_checker (.*);

>>> tb/sv/testbench.sv
// Testbench: random and directed words against a mirror of the lookup-accumulate block.
`timescale 1ns / 100ps

module testbench;
  import lia_pkg::*;

  // Mirror of the lookup entries and accumulators, plus the read words still due.
  class acc_mirror;
    logic [7:0]         entry [LUT_DEPTH];
    bit                 written [LUT_DEPTH];
    logic [31:0]        acc [ACC_DEPTH];
    logic signed [31:0] reads_due [$];
    int                 errors;

    function new();
      foreach (acc[i]) acc[i] = '0;
      foreach (written[i]) written[i] = 1'b0;
      foreach (entry[i]) entry[i] = '0;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function bit group_has_entry(logic [3:0] grp);
      for (int s = 0; s < ENTRIES_PER_GROUP; s++)
        if (written[grp * ENTRIES_PER_GROUP + s]) return 1'b1;
      return 1'b0;
    endfunction

    function void add_entry(int addr, logic [7:0] e);
      if (addr < ACC_DEPTH) acc[addr] = acc[addr] + {{24{e[7]}}, e};
    endfunction

    function void apply_word(op_t op, logic [3:0] grp, logic [3:0] slot,
                             logic [7:0] val, logic [7:0] idx, logic [2:0] blk,
                             logic [3:0] pos, logic [7:0] raddr);
      int base;
      base = grp * ENTRIES_PER_GROUP;
      case (op)
        OP_LUT_WRITE: begin
          if (grp < GROUPS) begin
            entry[base + slot] = val;
            written[base + slot] = 1'b1;
          end
        end
        OP_ACCUMULATE: begin
          if (grp < GROUPS) begin
            add_entry(blk * 32 + pos, entry[base + idx[3:0]]);
            add_entry(blk * 32 + 16 + pos, entry[base + idx[7:4]]);
          end
        end
        OP_CLEAR: begin
          foreach (acc[i]) acc[i] = '0;
        end
        default: begin
          reads_due.push_back((raddr < ACC_DEPTH) ? acc[raddr] : 32'sd0);
        end
      endcase
    endfunction

    function void check_read_value(logic signed [31:0] got);
      logic signed [31:0] want;
      if (reads_due.size() == 0) begin
        report($sformatf("read word %0d with none pending", got));
      end else begin
        want = reads_due.pop_front();
        if (got !== want) report($sformatf("read_value exp %0d got %0d", want, got));
      end
    endfunction

    function int pending();
      return reads_due.size();
    endfunction

    function void close();
      if (reads_due.size() != 0)
        report($sformatf("%0d read words never arrived", reads_due.size()));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  op_t                operation;
  logic [3:0]         lut_group;
  logic [3:0]         lut_slot;
  logic signed [7:0]  lut_value;
  logic [7:0]         index_byte;
  logic [2:0]         row_block;
  logic [3:0]         byte_position;
  logic [7:0]         read_address;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] read_value;

  acc_mirror mirror = new();

  bit   calm;
  bit   hold_req;
  int   hold_left;
  logic [7:0] last_acc_addr;

  lut_int8_int32_accumulate u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .lut_group     (lut_group),
    .lut_slot      (lut_slot),
    .lut_value     (lut_value),
    .index_byte    (index_byte),
    .row_block     (row_block),
    .byte_position (byte_position),
    .read_address  (read_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_value    (read_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Offer one word, optionally after an idle gap, and hold it until accepted.
  task automatic send_word(op_t op, logic [3:0] grp, logic [3:0] slot, logic [7:0] val,
                           logic [7:0] idx, logic [2:0] blk, logic [3:0] pos,
                           logic [7:0] raddr);
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    lut_group     <= grp;
    lut_slot      <= slot;
    lut_value     <= val;
    index_byte    <= idx;
    row_block     <= blk;
    byte_position <= pos;
    read_address  <= raddr;
    do @(posedge clk); while (!in_ready);
    mirror.apply_word(op, grp, slot, val, idx, blk, pos, raddr);
  endtask

  // Pick a slot of the group that has been written since reset.
  function automatic logic [3:0] pick_written_slot(logic [3:0] grp);
    logic [3:0] s;
    do s = 4'($urandom); while (!mirror.written[grp * ENTRIES_PER_GROUP + s]);
    return s;
  endfunction

  task automatic send_random_word();
    op_t        op;
    int         r;
    logic [3:0] grp, slot, pos;
    logic [7:0] val, idx, raddr;
    logic [2:0] blk;
    r     = $urandom_range(99);
    grp   = 4'($urandom);
    slot  = 4'($urandom);
    val   = 8'($urandom);
    idx   = 8'($urandom);
    blk   = 3'($urandom);
    pos   = 4'($urandom);
    raddr = 8'($urandom);
    if (r < 22) op = OP_LUT_WRITE;
    else if (r < 66) op = OP_ACCUMULATE;
    else if (r < 67) op = OP_CLEAR;
    else op = OP_READ;
    // Never let an index byte select an entry that was never written.
    if (op == OP_ACCUMULATE) begin
      if (!mirror.group_has_entry(grp)) begin
        op = OP_LUT_WRITE;
      end else begin
        idx = {pick_written_slot(grp), pick_written_slot(grp)};
        last_acc_addr = {blk, r[0], pos};
      end
    end
    if (op == OP_READ && $urandom_range(1) == 1) raddr = last_acc_addr;
    send_word(op, grp, slot, val, idx, blk, pos, raddr);
  endtask

  // Receiver: check read words, stall at random, and hold off once for a long stretch.
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) mirror.check_read_value(read_value);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin
    calm          = 1'b0;
    hold_req      = 1'b0;
    last_acc_addr = '0;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    operation     <= OP_LUT_WRITE;
    lut_group     <= '0;
    lut_slot      <= '0;
    lut_value     <= '0;
    index_byte    <= '0;
    row_block     <= '0;
    byte_position <= '0;
    read_address  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: value extremes, nibble extremes, corner accumulators, clear.
    send_word(OP_LUT_WRITE, 4'd0, 4'd0, 8'h80, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_LUT_WRITE, 4'd0, 4'd15, 8'h7f, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_LUT_WRITE, 4'd15, 4'd0, 8'hff, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_LUT_WRITE, 4'd15, 4'd15, 8'h01, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_LUT_WRITE, 4'd9, 4'd6, 8'h00, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_ACCUMULATE, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_ACCUMULATE, 4'd0, 4'd0, 8'h00, 8'hff, 3'd7, 4'd15, 8'd0);
    send_word(OP_ACCUMULATE, 4'd0, 4'd0, 8'h00, 8'hf0, 3'd0, 4'd0, 8'd0);
    send_word(OP_ACCUMULATE, 4'd15, 4'd0, 8'h00, 8'h0f, 3'd3, 4'd9, 8'd0);
    send_word(OP_ACCUMULATE, 4'd9, 4'd0, 8'h00, 8'h66, 3'd5, 4'd2, 8'd0);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd16);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd239);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd255);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd105);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd1);
    send_word(OP_CLEAR, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd0);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd255);
    send_word(OP_ACCUMULATE, 4'd15, 4'd0, 8'h00, 8'hf0, 3'd7, 4'd15, 8'd0);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd255);
    send_word(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 3'd0, 4'd0, 8'd239);

    for (int i = 0; i < 750; i++) begin
      calm = (i >= 300 && i < 420);
      // Stall the receiver long enough to back the block up into its input.
      if (i == 520) hold_req = 1'b1;
      send_random_word();
    end
    in_valid <= 1'b0;

    while (mirror.pending() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
    mirror.close();
    if (mirror.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/lia_pkg.sv
src/lia_ram.sv
src/lut_int8_int32_accumulate.sv
src/lia_checker.sv
tb/sv/testbench.sv
